// File: src/two_slot_bound_table_update_core_assert.svh
// Assertion macros for the bound table core.
`ifndef TWO_SLOT_BOUND_TABLE_UPDATE_CORE_ASSERT_SVH
`define TWO_SLOT_BOUND_TABLE_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TBU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TBU_ASSERT_R(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TBU_ASSERT(label, clk, rst_n, prop, msg)
`define TBU_ASSERT_R(label, clk, prop, msg)
`endif
`endif

// File: src/tbu_pkg.sv
// Shared types and constants of the bound table core.
package tbu_pkg;
	localparam int TABLE_BITS   = 16;
	localparam int TABLE_SIZE   = 1 << TABLE_BITS;
	localparam int SCORE_LIMIT  = 64;
	localparam logic [7:0] NO_MOVE_CODE = 8'd255;
	localparam int SLOT_W       = 192;
	localparam int ENTRY_W      = 2 * SLOT_W;

	typedef logic [TABLE_BITS-1:0] idx_t;

	localparam logic [1:0] REQ_WINDOW  = 2'd0;
	localparam logic [1:0] REQ_ONESIDE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP  = 2'd2;
	localparam logic [1:0] REQ_PROTECT = 2'd3;

	localparam logic [1:0] HALF_SHARED = 2'd0;
	localparam logic [1:0] HALF_BLACK  = 2'd1;
	localparam logic [1:0] HALF_WHITE  = 2'd2;

	localparam logic [1:0] CFG_SHARED_MODE = 2'd0;
	localparam logic [1:0] CFG_DATE_SB     = 2'd1;
	localparam logic [1:0] CFG_DATE_W      = 2'd2;

	typedef struct packed {
		logic [7:0]         date;
		logic [7:0]         depth;
		logic [7:0]         sel;
		logic [7:0]         move;
		logic signed [15:0] upper;
		logic signed [15:0] lower;
	} info_t;

	typedef struct packed {
		logic [63:0] kp;
		logic [63:0] ko;
		info_t       info;
	} slot_t;

	typedef struct packed {
		slot_t deep;
		slot_t newr;
	} entry_t;

	typedef struct packed {
		logic [1:0]         req;
		idx_t               idx;
		logic [7:0]         base;
		logic [63:0]        kp;
		logic [63:0]        ko;
		logic [7:0]         sel;
		logic [7:0]         depth;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic signed [15:0] score;
		logic [7:0]         mv;
	} req_t;

	typedef struct packed {
		logic               found;
		logic signed [15:0] lower;
		logic signed [15:0] upper;
		logic [7:0]         move;
		logic [7:0]         depth;
		logic [7:0]         sel;
		logic [7:0]         date;
	} res_t;
endpackage

// File: src/tbu_ram.sv
// Generic single-port-write, registered-read RAM.
module tbu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/tbu_logic.sv
// Entry modify logic: update, lookup and protect rules.
module tbu_logic (
	input  tbu_pkg::req_t   rq,
	input  tbu_pkg::entry_t ent,
	output tbu_pkg::entry_t nxt,
	output logic            wr,
	output tbu_pkg::res_t   res
);
	import tbu_pkg::*;

	localparam logic signed [15:0] SL = 16'(SCORE_LIMIT);

	// beta is 17 bits: a one-sided update with alpha at the top of the range
	// puts beta one above the 16-bit range
	function automatic info_t do_merge(info_t r, logic signed [15:0] s,
			logic signed [15:0] a, logic signed [16:0] b, logic [7:0] mv);
		info_t o;
		o = r;
		if (s < b && s < r.upper) o.upper = s;
		if (s > a) begin
			o.move = mv;
			if (s > r.lower) o.lower = s;
		end
		if (o.lower > o.upper) begin
			o.lower = (s > a) ? s : -SL;
			o.upper = (s < b) ? s : SL;
			o.move  = mv;
		end
		return o;
	endfunction

	function automatic logic merge_fix(info_t r, logic signed [15:0] s,
			logic signed [15:0] a, logic signed [16:0] b);
		logic signed [15:0] lo, up;
		lo = r.lower;
		up = r.upper;
		if (s < b && s < r.upper) up = s;
		if (s > a && s > r.lower) lo = s;
		return lo > up;
	endfunction

	always_comb begin
		logic               win, isd, isn;
		logic signed [16:0] b;
		logic [8:0]         d;
		info_t              dv, nv, mi;
		slot_t              fresh;
		win = (rq.req == REQ_WINDOW);
		isd = (rq.kp == ent.deep.kp) && (rq.ko == ent.deep.ko);
		isn = (rq.kp == ent.newr.kp) && (rq.ko == ent.newr.ko);
		dv  = ent.deep.info;
		nv  = ent.newr.info;
		mi  = dv;
		b   = win ? 17'(rq.beta) : 17'(rq.alpha) + 17'sd1;
		d   = {1'b0, rq.base};
		if (win && rq.alpha < rq.score && rq.score < rq.beta) d = d + 9'd1;
		fresh.kp          = rq.kp;
		fresh.ko          = rq.ko;
		fresh.info.depth  = rq.depth;
		fresh.info.sel    = rq.sel;
		fresh.info.move   = rq.mv;
		fresh.info.date   = d[7:0];
		fresh.info.lower  = (rq.score > rq.alpha) ? rq.score : -SL;
		fresh.info.upper  = (rq.score < b) ? rq.score : SL;
		nxt = ent;
		wr  = 1'b0;
		res = '0;
		res.move = NO_MOVE_CODE;
		case (rq.req)
			REQ_WINDOW, REQ_ONESIDE: begin
				wr = 1'b1;
				if (isd && rq.depth == dv.depth && rq.sel == dv.sel) begin
					mi = do_merge(dv, rq.score, rq.alpha, b, rq.mv);
					if (!(merge_fix(dv, rq.score, rq.alpha, b)) && win
							&& mi.lower == mi.upper && d == {1'b0, rq.base})
						d = d + 9'd1;
					mi.date = d[7:0];
					nxt.deep.info = mi;
				end else if (isn && rq.depth == nv.depth && rq.sel == nv.sel) begin
					mi = do_merge(nv, rq.score, rq.alpha, b, rq.mv);
					mi.date = d[7:0];
					if (mi.date > dv.date || (mi.date == dv.date && rq.depth > dv.depth)) begin
						nxt.newr = ent.deep;
						nxt.deep.kp = rq.kp;
						nxt.deep.ko = rq.ko;
						nxt.deep.info = mi;
					end else begin
						nxt.newr.info = mi;
					end
				end else if (isd || {1'b0, dv.date} < d || ({1'b0, dv.date} == d
						&& (dv.depth < rq.depth || (dv.depth == rq.depth && dv.sel < rq.sel)))) begin
					if (!isd && (isn || nv.date < dv.date || (nv.date == dv.date
							&& (nv.depth < dv.depth || (nv.depth == dv.depth && nv.sel <= dv.sel)))))
						nxt.newr = ent.deep;
					nxt.deep = fresh;
				end else begin
					nxt.newr = fresh;
				end
			end
			REQ_LOOKUP: begin
				if (isd || isn) begin
					mi = isd ? dv : nv;
					res = '{1'b1, mi.lower, mi.upper, mi.move, mi.depth, mi.sel, mi.date};
				end
			end
			default: begin
				if (isn || isd) begin
					if (isn) begin
						nxt.deep = ent.newr;
						nxt.newr = ent.deep;
					end
					mi = nxt.deep.info;
					if (mi.move != NO_MOVE_CODE) begin
						mi.date = 8'(rq.base + 8'd1);
						wr = 1'b1;
					end
					wr = wr | isn;
					nxt.deep.info = mi;
					res = '{1'b1, mi.lower, mi.upper, mi.move, mi.depth, mi.sel, mi.date};
				end
			end
		endcase
	end
endmodule

// File: src/two_slot_bound_table_update_core.sv
// Top level: two-slot bound table with read-modify-write over one entry RAM.
// Usage:
//  s_axis carries one request item per handshake; m_axis returns exactly one
//  result item per request (updates return a blank result with no-move code).
//  On acceptance, in the idle state, the indexed entry (both slots, 384 bits)
//  is read from the RAM; in the READ state it is read again at the registered
//  request index, and in the WRITE state the modified entry is written back
//  and the output register is loaded. A new item is taken once the core is
//  idle and the result register is free or being drained, so each item goes
//  through accept, read and write-back before the next one is taken.
//  Configuration (cfg_we/cfg_index/cfg_data) is to be written only while idle;
//  the core does not enforce this. After reset a clearing pass writes zero to
//  all TABLE_SIZE (65536) entries, one per cycle, with s_axis_tready low.
//  While a result waits on m_axis_tready it is held and no new item is taken.
module two_slot_bound_table_update_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// req_type, hash_high, table_half, player_discs, opponent_discs,
	// search_selectivity, search_depth, window_low, window_high,
	// result_score, best_move_in, zero pad (240 bits in all)
	input  logic [239:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found, bound_lower, bound_upper, best_move_out, stored_depth,
	// stored_selectivity, stored_date, zero pad (72 bits in all)
	output logic [71:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);
	import tbu_pkg::*;
	`include "two_slot_bound_table_update_core_assert.svh"

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_WRITE} st_t;

	st_t              st_q;
	idx_t             clr_q;
	logic             mode_q;
	logic [7:0]       dsb_q, dw_q;
	req_t             rq_s1;
	res_t             res_q;
	logic             ovld_q;
	entry_t           rd, nxt;
	logic             wr;
	res_t             res;
	logic             ram_we;
	idx_t             ram_wa, ram_ra, idx;
	logic [1:0]       half;
	logic [31:0]      hash;
	logic             take;

	assign hash = s_axis_tdata[33:2];
	assign half = s_axis_tdata[35:34];
	always_comb begin
		case (half)
			HALF_BLACK: idx = {1'b0, hash[TABLE_BITS-2:0]};
			HALF_WHITE: idx = {1'b1, hash[TABLE_BITS-2:0]};
			default:    idx = hash[TABLE_BITS-1:0];
		endcase
	end

	assign s_axis_tready = (st_q == ST_IDLE) && (!ovld_q || m_axis_tready);
	assign take = s_axis_tvalid && s_axis_tready;
	assign ram_ra = (st_q == ST_IDLE) ? idx : rq_s1.idx;
	assign ram_we = (st_q == ST_CLEAR) || (st_q == ST_WRITE && wr);
	assign ram_wa = (st_q == ST_CLEAR) ? clr_q : rq_s1.idx;

	tbu_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa),
		.wdata((st_q == ST_CLEAR) ? '0 : nxt), .raddr(ram_ra), .rdata(rd)
	);

	tbu_logic u_logic (.rq(rq_s1), .ent(rd), .nxt(nxt), .wr(wr), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			clr_q  <= '0;
			mode_q <= 1'b1;
			dsb_q  <= '0;
			dw_q   <= '0;
			ovld_q <= 1'b0;
			rq_s1  <= '0;
			res_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHARED_MODE: mode_q <= cfg_data[0];
					CFG_DATE_SB:     dsb_q <= cfg_data;
					CFG_DATE_W:      dw_q <= cfg_data;
					default: ;
				endcase
			end
			if (ovld_q && m_axis_tready) ovld_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take) begin
						st_q <= ST_READ;
						rq_s1.req   <= s_axis_tdata[1:0];
						rq_s1.idx   <= idx;
						rq_s1.base  <= (mode_q || half != HALF_WHITE) ? dsb_q : dw_q;
						rq_s1.kp    <= s_axis_tdata[99:36];
						rq_s1.ko    <= s_axis_tdata[163:100];
						rq_s1.sel   <= s_axis_tdata[171:164];
						rq_s1.depth <= s_axis_tdata[179:172];
						rq_s1.alpha <= s_axis_tdata[195:180];
						rq_s1.beta  <= s_axis_tdata[211:196];
						rq_s1.score <= s_axis_tdata[227:212];
						rq_s1.mv    <= s_axis_tdata[235:228];
					end
				end
				ST_READ: st_q <= ST_WRITE;
				default: begin
					st_q   <= ST_IDLE;
					res_q  <= res;
					ovld_q <= 1'b1;
				end
			endcase
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata = {7'd0, res_q.date, res_q.sel, res_q.depth, res_q.move,
		res_q.upper, res_q.lower, res_q.found};

	`TBU_ASSERT(a_no_take_busy, clk, arst_n, (st_q != ST_IDLE) |-> !s_axis_tready,
		"item taken while busy")
	`TBU_ASSERT(a_write_after_read, clk, arst_n, (st_q == ST_READ) |=> (st_q == ST_WRITE),
		"read not followed by write-back")
	`TBU_ASSERT(a_result_after_write, clk, arst_n, (st_q == ST_WRITE) |=> m_axis_tvalid,
		"no result after write-back")
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the two-slot bound table core: directed and random updates, lookups, protects.
module tb_top;
	import tbu_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_ITEMS = 360;

	typedef struct {
		bit [1:0]         req;
		bit [31:0]        hash;
		bit [1:0]         half;
		bit [63:0]        kp;
		bit [63:0]        ko;
		bit [7:0]         sel;
		bit [7:0]         depth;
		bit signed [15:0] alpha;
		bit signed [15:0] beta;
		bit signed [15:0] score;
		bit [7:0]         mv;
	} probe_t;

	typedef struct {
		int lower;
		int upper;
		int mv;
		int sel;
		int depth;
		int date;
	} rec_s;

	class bound_table_sb;
		bit [63:0] deep_kp[TABLE_SIZE];
		bit [63:0] deep_ko[TABLE_SIZE];
		bit [63:0] deep_inf[TABLE_SIZE];
		bit [63:0] newr_kp[TABLE_SIZE];
		bit [63:0] newr_ko[TABLE_SIZE];
		bit [63:0] newr_inf[TABLE_SIZE];
		bit shared_mode = 1;
		bit [7:0] date_sb = 0;
		bit [7:0] date_w = 0;
		res_t pending[$];
		int errors = 0;

		function rec_s unpk(bit [63:0] w);
			rec_s r;
			r.lower = $signed(w[15:0]);
			r.upper = $signed(w[31:16]);
			r.mv = w[39:32];
			r.sel = w[47:40];
			r.depth = w[55:48];
			r.date = w[63:56];
			return r;
		endfunction

		function bit [63:0] pk(rec_s r);
			bit [15:0] lo, up;
			bit [7:0] m, s, dp, dt;
			lo = r.lower[15:0];
			up = r.upper[15:0];
			m = r.mv[7:0];
			s = r.sel[7:0];
			dp = r.depth[7:0];
			dt = r.date[7:0];
			return {dt, dp, s, m, up, lo};
		endfunction

		function void copy_down(int i);
			newr_kp[i] = deep_kp[i];
			newr_ko[i] = deep_ko[i];
			newr_inf[i] = deep_inf[i];
		endfunction

		function rec_s merge_score(rec_s r, int score, int alpha, int beta, int mv);
			if (score < beta && score < r.upper) r.upper = score;
			if (score > alpha) begin
				r.mv = mv;
				if (score > r.lower) r.lower = score;
			end
			return r;
		endfunction

		function rec_s fresh_bounds(rec_s r, int score, int alpha, int beta);
			r.lower = (score > alpha) ? score : -SCORE_LIMIT;
			r.upper = (score < beta) ? score : SCORE_LIMIT;
			return r;
		endfunction

		function void apply_update(int i, int base, bit win, probe_t t);
			int d, alpha, beta, score, mv, sel, depth;
			rec_s dv, nv;
			bit isd, isn;
			d = base;
			alpha = t.alpha;
			beta = t.beta;
			score = t.score;
			mv = t.mv;
			sel = t.sel;
			depth = t.depth;
			dv = unpk(deep_inf[i]);
			isd = (t.kp == deep_kp[i] && t.ko == deep_ko[i]);
			if (!win) beta = alpha + 1;
			else if (alpha < score && score < beta) d++;
			if (isd && depth == dv.depth && sel == dv.sel) begin
				dv = merge_score(dv, score, alpha, beta, mv);
				if (dv.lower > dv.upper) begin
					dv = fresh_bounds(dv, score, alpha, beta);
					dv.mv = mv;
				end else if (win && dv.lower == dv.upper && d == base) begin
					d++;
				end
				dv.date = d & 255;
				deep_inf[i] = pk(dv);
				return;
			end
			nv = unpk(newr_inf[i]);
			isn = (t.kp == newr_kp[i] && t.ko == newr_ko[i]);
			if (isn && depth == nv.depth && sel == nv.sel) begin
				nv = merge_score(nv, score, alpha, beta, mv);
				if (nv.lower > nv.upper) begin
					nv = fresh_bounds(nv, score, alpha, beta);
					nv.mv = mv;
				end
				nv.date = d & 255;
				if (nv.date > dv.date || (nv.date == dv.date && depth > dv.depth)) begin
					copy_down(i);
					deep_kp[i] = t.kp;
					deep_ko[i] = t.ko;
					deep_inf[i] = pk(nv);
				end else begin
					newr_inf[i] = pk(nv);
				end
			end else if (isd || dv.date < d || (dv.date == d && (dv.depth < depth ||
					(dv.depth == depth && dv.sel < sel)))) begin
				if (!isd && (isn || nv.date < dv.date || (nv.date == dv.date &&
						(nv.depth < dv.depth || (nv.depth == dv.depth && nv.sel <= dv.sel)))))
					copy_down(i);
				deep_kp[i] = t.kp;
				deep_ko[i] = t.ko;
				dv.depth = depth;
				dv.date = d & 255;
				dv.sel = sel;
				dv.mv = mv;
				dv = fresh_bounds(dv, score, alpha, beta);
				deep_inf[i] = pk(dv);
			end else begin
				newr_kp[i] = t.kp;
				newr_ko[i] = t.ko;
				nv.depth = depth;
				nv.date = d & 255;
				nv.sel = sel;
				nv.mv = mv;
				nv = fresh_bounds(nv, score, alpha, beta);
				newr_inf[i] = pk(nv);
			end
		endfunction

		function void write_reg(bit [1:0] index, bit [7:0] value);
			case (index)
				CFG_SHARED_MODE: shared_mode = value[0];
				CFG_DATE_SB: date_sb = value;
				CFG_DATE_W: date_w = value;
				default: ;
			endcase
		endfunction

		function void note_request(probe_t t);
			int i, base;
			bit hit, fn, fd;
			rec_s r;
			bit [63:0] a, b, c;
			res_t e;
			if (t.half == HALF_BLACK) i = t.hash[14:0];
			else if (t.half == HALF_WHITE) i = {1'b1, t.hash[14:0]};
			else i = t.hash[15:0];
			base = (shared_mode || t.half != HALF_WHITE) ? date_sb : date_w;
			r = '{0, 0, NO_MOVE_CODE, 0, 0, 0};
			hit = 0;
			if (t.req == REQ_WINDOW || t.req == REQ_ONESIDE) begin
				apply_update(i, base, t.req == REQ_WINDOW, t);
			end else if (t.req == REQ_LOOKUP) begin
				if (t.kp == deep_kp[i] && t.ko == deep_ko[i]) begin
					r = unpk(deep_inf[i]);
					hit = 1;
				end else if (t.kp == newr_kp[i] && t.ko == newr_ko[i]) begin
					r = unpk(newr_inf[i]);
					hit = 1;
				end
			end else begin
				fn = (t.kp == newr_kp[i] && t.ko == newr_ko[i]);
				fd = (t.kp == deep_kp[i] && t.ko == deep_ko[i]);
				if (fn) begin
					a = deep_kp[i];
					b = deep_ko[i];
					c = deep_inf[i];
					deep_kp[i] = newr_kp[i];
					deep_ko[i] = newr_ko[i];
					deep_inf[i] = newr_inf[i];
					newr_kp[i] = a;
					newr_ko[i] = b;
					newr_inf[i] = c;
					fd = 1;
				end
				if (fd) begin
					r = unpk(deep_inf[i]);
					if (r.mv != NO_MOVE_CODE) begin
						r.date = (base + 1) & 255;
						deep_inf[i] = pk(r);
					end
					hit = 1;
				end
			end
			e.found = hit;
			e.lower = r.lower[15:0];
			e.upper = r.upper[15:0];
			e.move = r.mv[7:0];
			e.depth = r.depth[7:0];
			e.sel = r.sel[7:0];
			e.date = r.date[7:0];
			pending = {pending, e};
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(logic [71:0] d);
			res_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected item %h", d));
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e.found) report($sformatf("found %b exp %b", d[0], e.found));
			if (d[16:1] !== e.lower) report($sformatf("lower %h exp %h", d[16:1], e.lower));
			if (d[32:17] !== e.upper) report($sformatf("upper %h exp %h", d[32:17], e.upper));
			if (d[40:33] !== e.move) report($sformatf("move %h exp %h", d[40:33], e.move));
			if (d[48:41] !== e.depth) report($sformatf("depth %h exp %h", d[48:41], e.depth));
			if (d[56:49] !== e.sel) report($sformatf("sel %h exp %h", d[56:49], e.sel));
			if (d[64:57] !== e.date) report($sformatf("date %h exp %h", d[64:57], e.date));
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [239:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [71:0]  m_axis_tdata;
	logic         cfg_we = 0;
	logic [1:0]   cfg_index = '0;
	logic [7:0]   cfg_data = '0;

	bound_table_sb sb = new();
	bit steady = 0;
	int cycles = 0;
	int sink_stall = 0;
	bit [63:0] key_p[6];
	bit [63:0] key_o[6];
	bit [15:0] hot_idx[4];

	two_slot_bound_table_update_core uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_slot_bound_table_update_core test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if (sink_stall > 0) begin
				m_axis_tready <= 0;
				sink_stall <= sink_stall - 1;
			end else begin
				m_axis_tready <= 1;
				if ($urandom_range(0, 9) == 0) sink_stall <= pick_gap();
			end
		end
	end

	task send_item(probe_t t);
		int g;
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, t.mv, t.score, t.beta, t.alpha, t.depth, t.sel, t.ko, t.kp,
			t.half, t.hash, t.req};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(t);
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task write_cfg(bit [1:0] index, bit [7:0] value);
		cfg_we <= 1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(index, value);
		cfg_we <= 0;
	endtask

	task drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function int full_score();
		return int'($urandom_range(0, 65534)) - 32767;
	endfunction

	function probe_t random_item();
		probe_t t;
		int k, r, a;
		r = $urandom_range(0, 99);
		t.req = r < 35 ? REQ_WINDOW : r < 60 ? REQ_ONESIDE : r < 85 ? REQ_LOOKUP : REQ_PROTECT;
		t.hash = $urandom();
		if ($urandom_range(0, 9) < 8) t.hash[15:0] = hot_idx[$urandom_range(0, 3)];
		r = $urandom_range(0, 19);
		t.half = r == 0 ? 2'd3 : r < 7 ? HALF_SHARED : r < 13 ? HALF_BLACK : HALF_WHITE;
		k = $urandom_range(0, 5);
		t.kp = key_p[k];
		t.ko = key_o[k];
		if ($urandom_range(0, 19) == 0) t.kp = {$urandom(), $urandom()};
		if ($urandom_range(0, 19) == 0) t.ko = {$urandom(), $urandom()};
		t.sel = 8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 1));
		t.depth = 8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			t.alpha = 16'(full_score());
			t.beta = 16'(full_score());
			t.score = 16'(full_score());
		end else begin
			a = int'($urandom_range(0, 140)) - 70;
			t.alpha = 16'(a);
			t.beta = 16'(a + int'($urandom_range(1, 40)));
			t.score = 16'(a + int'($urandom_range(0, 60)) - 20);
		end
		t.mv = $urandom_range(0, 9) == 0 ? NO_MOVE_CODE : 8'($urandom_range(0, 255));
		return t;
	endfunction

	task directed();
		probe_t t;
		t = '{REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_item(t);
		t.req = REQ_PROTECT;
		send_item(t);
		t = '{REQ_WINDOW, 32'hFFFF_FFFF, HALF_BLACK, key_p[1], key_o[1], 8'hFF, 8'hFF,
			-16'sd32767, 16'sd32767, 16'sd32767, 8'hFF};
		send_item(t);
		t.req = REQ_LOOKUP;
		send_item(t);
		t = '{REQ_WINDOW, 32'h0000_0005, HALF_WHITE, key_p[2], key_o[2], 8'd3, 8'd7,
			-16'sd10, 16'sd10, 16'sd2, 8'd12};
		send_item(t);
		t.score = 2;
		send_item(t);
		t.req = REQ_LOOKUP;
		send_item(t);
		t = '{REQ_ONESIDE, 32'h0000_0005, HALF_WHITE, key_p[3], key_o[3], 8'd0, 8'd0,
			16'sd32767, 16'sd0, -16'sd32767, 8'd0};
		send_item(t);
		t.depth = 9;
		t.score = 16'sd32767;
		t.kp = key_p[4];
		t.ko = key_o[4];
		send_item(t);
		t.req = REQ_PROTECT;
		t.kp = key_p[3];
		t.ko = key_o[3];
		send_item(t);
		t.req = REQ_LOOKUP;
		send_item(t);
		t = '{REQ_WINDOW, 32'hABCD_0005, 2'd3, key_p[2], key_o[2], 8'd3, 8'd7,
			16'sd5, -16'sd5, 16'sd0, NO_MOVE_CODE};
		send_item(t);
		t.half = HALF_SHARED;
		t.req = REQ_PROTECT;
		send_item(t);
		t.req = REQ_LOOKUP;
		t.hash = 32'h5555_AAAA;
		send_item(t);
		t.hash = 32'hAAAA_5555;
		t.half = HALF_BLACK;
		send_item(t);
	endtask

	initial begin
		int ph;
		bit [7:0] cfg_set[5][3];
		cfg_set = '{'{1, 0, 0}, '{0, 255, 3}, '{0, 10, 255}, '{1, 255, 255}, '{0, 0, 128}};
		key_p[0] = '0;
		key_o[0] = '0;
		key_p[1] = '1;
		key_o[1] = '1;
		for (int k = 2; k < 6; k++) begin
			key_p[k] = {$urandom(), $urandom()};
			key_o[k] = {$urandom(), $urandom()};
		end
		for (int k = 0; k < 4; k++) hot_idx[k] = 16'($urandom());
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		drain();
		for (ph = 0; ph < 5; ph++) begin
			write_cfg(CFG_SHARED_MODE, cfg_set[ph][0]);
			write_cfg(CFG_DATE_SB, cfg_set[ph][1]);
			write_cfg(CFG_DATE_W, cfg_set[ph][2]);
			steady = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
			steady = 0;
			drain();
		end
		if (sb.errors == 0) $display("two_slot_bound_table_update_core test passed");
		else $display("two_slot_bound_table_update_core test failed");
		$finish;
	end
endmodule
